/* sv/sve_pkg.sv */
// ----------------------------------------------------------------------------
// sve_pkg
// Shared types and constants of the stack machine executor.
// ----------------------------------------------------------------------------
package sve_pkg;

  localparam int unsigned W = 32;
  localparam int unsigned CNT_W = $clog2(W + 1);
  localparam logic [15:0] SB_RESET = 16'd64512;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW = $clog2(Q_DEPTH + 1);

  localparam logic CFG_FRAME_BASE = 1'b0;
  localparam logic CFG_STACK_BASE = 1'b1;

  typedef enum logic [3:0] {
    CL_NOP, CL_PUSH_VAL, CL_PUSH_MEM, CL_POP, CL_ADJ, CL_BIN,
    CL_UNARY, CL_ASSIGN, CL_JMP, CL_JCOND, CL_HOST, CL_BAD
  } cls_t;

  // order follows the binary opcodes, plain move last
  typedef enum logic [4:0] {
    ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_REM, ALU_SHL, ALU_SHR,
    ALU_LE, ALU_GT, ALU_LT, ALU_GE, ALU_EQ, ALU_NE, ALU_OR, ALU_AND,
    ALU_XOR, ALU_LOR, ALU_LAND, ALU_MOV
  } alu_t;

  typedef enum logic [2:0] {
    UN_PREINC, UN_PREDEC, UN_ADDR, UN_DEREF, UN_NOT, UN_INV,
    UN_POSTINC, UN_POSTDEC
  } un_t;

  typedef enum logic [2:0] {
    FLT_NONE, FLT_UNKNOWN, FLT_UNDER, FLT_OVER, FLT_DIV0, FLT_ADDR, FLT_ADJUST
  } fault_t;

  typedef enum logic [3:0] {
    ST_START, ST_POP1, ST_POP2, ST_CHK, ST_MRD, ST_ALU, ST_DIVW,
    ST_WRM, ST_WRP, ST_FIN
  } st_t;

  typedef struct packed {
    cls_t        cls;
    alu_t        alu;
    un_t         un;
    logic        jz;
    logic        sub;
    logic [31:0] arg;
    logic [31:0] data;
  } uop_t;

endpackage

/* sv/stack_vm_executor.sv */
// ----------------------------------------------------------------------------
// stack_vm_executor
// Stack machine executor: decode queue in front, memory sequencer behind.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_op, in_arg, in_host_data
//   out     | output    | out_valid / out_ready | out_value, out_jump_taken,
//           |           |                       | out_jump_target, out_stack_level,
//           |           |                       | out_fault
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// Nop, adjust and faults caught up front go straight to completion; an
// immediate push or host write makes one write; binary ops and jumps pop
// first, compound assignment also reads and writes its target, and divide
// or remainder wait on the divider. The single read and single write port of
// the word memory set these steps. Reset is synchronous; the stack pointer
// returns to the stack base and the memory holds no defined contents until
// written. A two-entry queue lets the input side keep transferring while a
// result waits in the output register.
module stack_vm_executor
  import sve_pkg::*;
#(
  parameter int unsigned MEM_BYTES   = 65536,
  parameter int unsigned STACK_BYTES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [5:0]         in_op,
  input  logic signed [31:0] in_arg,
  input  logic signed [31:0] in_host_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic               out_jump_taken,
  output logic signed [31:0] out_jump_target,
  output logic [15:0]        out_stack_level,
  output logic [2:0]         out_fault,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [15:0] frame_base_r;
  logic [15:0] stack_base_r;
  logic        sb_load;
  logic        q_valid, q_pop;
  uop_t        q_uop;

  assign sb_load = cfg_we && (cfg_index == CFG_STACK_BASE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= '0;
      stack_base_r <= SB_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FRAME_BASE) frame_base_r <= cfg_data;
      else                             stack_base_r <= cfg_data;
    end
  end

  sve_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_arg       (in_arg),
    .in_host_data (in_host_data),
    .frame_base   (frame_base_r),
    .q_valid      (q_valid),
    .q_uop        (q_uop),
    .q_pop        (q_pop)
  );

  sve_exec #(
    .MEM_BYTES   (MEM_BYTES),
    .STACK_BYTES (STACK_BYTES)
  ) u_exec (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_uop           (q_uop),
    .q_pop           (q_pop),
    .stack_base      (stack_base_r),
    .sb_load         (sb_load),
    .sb_data         (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_jump_taken  (out_jump_taken),
    .out_jump_target (out_jump_target),
    .out_stack_level (out_stack_level),
    .out_fault       (out_fault)
  );

endmodule

/* sv/sve_front.sv */
// ----------------------------------------------------------------------------
// sve_front
// Decodes instructions into micro-ops and holds them in a short queue.
// ----------------------------------------------------------------------------
module sve_front
  import sve_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [5:0]         in_op,
  input  logic signed [31:0] in_arg,
  input  logic signed [31:0] in_host_data,
  input  logic [15:0]        frame_base,
  output logic               q_valid,
  output uop_t               q_uop,
  input  logic               q_pop
);

  localparam logic [5:0] OP_NOP       = 6'd0;
  localparam logic [5:0] OP_PUSH_IMM  = 6'd1;
  localparam logic [5:0] OP_PUSH_ABS  = 6'd2;
  localparam logic [5:0] OP_PUSH_FA   = 6'd3;
  localparam logic [5:0] OP_PUSH_FV   = 6'd4;
  localparam logic [5:0] OP_POP       = 6'd5;
  localparam logic [5:0] OP_SP_ADD    = 6'd6;
  localparam logic [5:0] OP_SP_SUB    = 6'd7;
  localparam logic [5:0] OP_BIN_FIRST = 6'd8;
  localparam logic [5:0] OP_BIN_LAST  = 6'd25;
  localparam logic [5:0] OP_UN_FIRST  = 6'd26;
  localparam logic [5:0] OP_UN_LAST   = 6'd33;
  localparam logic [5:0] OP_ASG_FIRST = 6'd34;
  localparam logic [5:0] OP_ASG_LAST  = 6'd44;
  localparam logic [5:0] OP_JMP       = 6'd45;
  localparam logic [5:0] OP_JZ        = 6'd46;
  localparam logic [5:0] OP_JNZ       = 6'd47;
  localparam logic [5:0] OP_HOST_WR   = 6'd48;

  function automatic alu_t asg_alu(input logic [3:0] idx);
    case (idx)
      4'd0:    return ALU_MOV;
      4'd1:    return ALU_ADD;
      4'd2:    return ALU_SUB;
      4'd3:    return ALU_MUL;
      4'd4:    return ALU_DIV;
      4'd5:    return ALU_REM;
      4'd6:    return ALU_SHL;
      4'd7:    return ALU_SHR;
      4'd8:    return ALU_AND;
      4'd9:    return ALU_OR;
      default: return ALU_XOR;
    endcase
  endfunction

  uop_t              dec;
  logic [31:0]       fb_arg;
  uop_t              q_mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   count_r, count_nxt;
  logic              push;

  assign fb_arg = {16'b0, frame_base} + in_arg;

  always_comb begin
    dec      = '0;
    dec.arg  = in_arg;
    dec.data = in_arg;
    dec.cls  = CL_BAD;
    if (in_op == OP_NOP) begin
      dec.cls = CL_NOP;
    end else if (in_op == OP_PUSH_IMM) begin
      dec.cls = CL_PUSH_VAL;
    end else if (in_op == OP_PUSH_ABS) begin
      dec.cls = CL_PUSH_MEM;
    end else if (in_op == OP_PUSH_FA) begin
      dec.cls  = CL_PUSH_VAL;
      dec.data = fb_arg;
    end else if (in_op == OP_PUSH_FV) begin
      dec.cls  = CL_PUSH_MEM;
      dec.data = fb_arg;
    end else if (in_op == OP_POP) begin
      dec.cls = CL_POP;
    end else if (in_op == OP_SP_ADD || in_op == OP_SP_SUB) begin
      dec.cls = CL_ADJ;
      dec.sub = (in_op == OP_SP_SUB);
    end else if (in_op >= OP_BIN_FIRST && in_op <= OP_BIN_LAST) begin
      dec.cls = CL_BIN;
      dec.alu = alu_t'(5'(in_op - OP_BIN_FIRST));
    end else if (in_op >= OP_UN_FIRST && in_op <= OP_UN_LAST) begin
      dec.cls = CL_UNARY;
      dec.un  = un_t'(3'(in_op - OP_UN_FIRST));
    end else if (in_op >= OP_ASG_FIRST && in_op <= OP_ASG_LAST) begin
      dec.cls = CL_ASSIGN;
      dec.alu = asg_alu(4'(in_op - OP_ASG_FIRST));
    end else if (in_op == OP_JMP) begin
      dec.cls = CL_JMP;
    end else if (in_op == OP_JZ || in_op == OP_JNZ) begin
      dec.cls = CL_JCOND;
      dec.jz  = (in_op == OP_JZ);
    end else if (in_op == OP_HOST_WR) begin
      dec.cls  = CL_HOST;
      dec.data = in_host_data;
    end
  end

  assign in_ready = (count_r != Q_CW'(Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign q_uop    = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CW'(push) - Q_CW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= dec;
    end
  end

endmodule

/* sv/sve_div.sv */
// ----------------------------------------------------------------------------
// sve_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sve_div
  import sve_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  logic [W-1:0]   quo_r, rem_r, dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic           busy_r, done_r;
  logic [W:0]     trial, diff;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // keep the trial remainder only when it did not go negative
      if (!diff[W]) begin
        rem_r <= diff[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= trial[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

/* sv/sve_exec.sv */
// ----------------------------------------------------------------------------
// sve_exec
// Sequencer that carries out one micro-op over the shared word memory.
// ----------------------------------------------------------------------------
module sve_exec
  import sve_pkg::*;
#(
  parameter int unsigned MEM_BYTES   = 65536,
  parameter int unsigned STACK_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  uop_t        q_uop,
  output logic        q_pop,
  input  logic [15:0] stack_base,
  input  logic        sb_load,
  input  logic [15:0] sb_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic        out_jump_taken,
  output logic [31:0] out_jump_target,
  output logic [15:0] out_stack_level,
  output logic [2:0]  out_fault
);

  localparam int unsigned WORDS = MEM_BYTES / 4;
  localparam int unsigned AW    = $clog2(WORDS);
  localparam logic [31:0] MAX_ADDR = 32'(MEM_BYTES - 4);

  function automatic logic addr_ok(input logic [31:0] a);
    return (a[1:0] == 2'b00) && (a <= MAX_ADDR);
  endfunction

  function automatic logic [31:0] alu_fn(input alu_t c, input logic [31:0] a,
                                         input logic [31:0] b);
    logic [31:0] r;
    r = '0;
    case (c)
      ALU_ADD:  r = a + b;
      ALU_SUB:  r = a - b;
      ALU_MUL:  r = a * b;
      ALU_SHL:  r = (b >= 32'd32) ? 32'd0 : (a << b[4:0]);
      ALU_SHR:  r = (b >= 32'd32) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
      ALU_LE:   r = 32'($signed(a) <= $signed(b));
      ALU_GT:   r = 32'($signed(a) > $signed(b));
      ALU_LT:   r = 32'($signed(a) < $signed(b));
      ALU_GE:   r = 32'($signed(a) >= $signed(b));
      ALU_EQ:   r = 32'(a == b);
      ALU_NE:   r = 32'(a != b);
      ALU_OR:   r = a | b;
      ALU_AND:  r = a & b;
      ALU_XOR:  r = a ^ b;
      ALU_LOR:  r = 32'(a != 0 || b != 0);
      ALU_LAND: r = 32'(a != 0 && b != 0);
      ALU_MOV:  r = b;
      default:  r = '0;
    endcase
    return r;
  endfunction

  st_t          state_r, state_nxt;
  logic [15:0]  sp_r;
  fault_t       fault_r;
  logic [31:0]  p1_r, p2_r, m_r, r_r;
  logic [31:0]  mem [WORDS];
  logic [31:0]  mem_q_r;
  logic         mem_re, mem_we;
  logic [31:0]  mem_raddr, mem_waddr, mem_wdata;

  logic         out_valid_r;
  logic [31:0]  out_value_r, out_jump_target_r;
  logic         out_jump_taken_r;
  logic [15:0]  out_stack_level_r;
  fault_t       out_fault_r;

  logic signed [17:0] depth;
  logic [31:0]  sp32, sp_m4, sp_m8;
  fault_t       pop1_f, pop2_f, push_f, adj_f, start_fault;
  logic signed [33:0] nsp, adepth;
  logic         two_pop, chk_fault, fin_go, jt;
  logic [31:0]  opa, opb, alu_res, un_res, alu_out, wv, div_fixed, ma, mb;
  logic         is_div, div_zero, un_writes;
  logic         div_start, div_busy, div_done;
  logic [31:0]  div_q, div_r;
  logic [15:0]  sp_fin;

  // ---------------- checks on the stack pointer ----------------
  assign depth = $signed({2'b0, sp_r}) - $signed({2'b0, stack_base});
  assign sp32  = {16'b0, sp_r};
  assign sp_m4 = sp32 - 32'd4;
  assign sp_m8 = sp32 - 32'd8;

  always_comb begin
    pop1_f = FLT_NONE;
    if (depth < 18'sd4)        pop1_f = FLT_UNDER;
    else if (!addr_ok(sp_m4))  pop1_f = FLT_ADDR;
    pop2_f = pop1_f;
    if (pop1_f == FLT_NONE) begin
      if (depth < 18'sd8)        pop2_f = FLT_UNDER;
      else if (!addr_ok(sp_m8))  pop2_f = FLT_ADDR;
    end
    push_f = FLT_NONE;
    if ((depth + 18'sd4 > $signed(18'(STACK_BYTES))) ||
        ({1'b0, sp_r} + 17'd4 > 17'h0FFFF)) push_f = FLT_OVER;
    else if (!addr_ok(sp32))                push_f = FLT_ADDR;
  end

  always_comb begin
    nsp    = q_uop.sub ? $signed({18'b0, sp_r}) - $signed({2'b0, q_uop.arg})
                       : $signed({18'b0, sp_r}) + $signed({2'b0, q_uop.arg});
    adepth = nsp - $signed({18'b0, stack_base});
    adj_f  = FLT_NONE;
    if (q_uop.arg[31] || q_uop.arg == 32'd0 || q_uop.arg[1:0] != 2'b00)
      adj_f = FLT_ADJUST;
    else if (adepth < 34'sd0)
      adj_f = FLT_UNDER;
    else if (adepth > $signed(34'(STACK_BYTES)) || nsp > 34'sh0FFFF)
      adj_f = FLT_OVER;
  end

  always_comb begin
    case (q_uop.cls)
      CL_NOP:      start_fault = FLT_NONE;
      CL_PUSH_VAL: start_fault = push_f;
      CL_PUSH_MEM: start_fault = !addr_ok(q_uop.data) ? FLT_ADDR : push_f;
      CL_POP: begin
        if (pop1_f != FLT_NONE)                          start_fault = pop1_f;
        else if (q_uop.arg != 0 && !addr_ok(q_uop.arg))  start_fault = FLT_ADDR;
        else                                             start_fault = FLT_NONE;
      end
      CL_ADJ:      start_fault = adj_f;
      CL_BIN, CL_ASSIGN, CL_JCOND: start_fault = pop2_f;
      CL_UNARY, CL_JMP:            start_fault = pop1_f;
      CL_HOST:     start_fault = addr_ok(q_uop.arg) ? FLT_NONE : FLT_ADDR;
      default:     start_fault = FLT_UNKNOWN;
    endcase
  end

  assign two_pop = (q_uop.cls == CL_BIN) || (q_uop.cls == CL_ASSIGN) ||
                   (q_uop.cls == CL_JCOND);
  assign chk_fault = ((q_uop.cls == CL_UNARY) && (q_uop.un != UN_ADDR) &&
                      !addr_ok(p1_r)) ||
                     ((q_uop.cls == CL_ASSIGN) && !addr_ok(p2_r));

  // ---------------- arithmetic ----------------
  assign opa      = (q_uop.cls == CL_ASSIGN) ? m_r : p2_r;
  assign opb      = p1_r;
  assign alu_res  = alu_fn(q_uop.alu, opa, opb);
  assign is_div   = ((q_uop.cls == CL_BIN) || (q_uop.cls == CL_ASSIGN)) &&
                    ((q_uop.alu == ALU_DIV) || (q_uop.alu == ALU_REM));
  assign div_zero = is_div && (opb == 32'd0);
  assign ma       = opa[31] ? 32'd0 - opa : opa;
  assign mb       = opb[31] ? 32'd0 - opb : opb;
  assign div_fixed = (q_uop.alu == ALU_DIV) ?
                     ((opa[31] ^ opb[31]) ? 32'd0 - div_q : div_q) :
                     (opa[31] ? 32'd0 - div_r : div_r);
  assign un_writes = (q_uop.un == UN_PREINC) || (q_uop.un == UN_PREDEC) ||
                     (q_uop.un == UN_POSTINC) || (q_uop.un == UN_POSTDEC);
  assign wv = ((q_uop.un == UN_PREINC) || (q_uop.un == UN_POSTINC)) ?
              m_r + 32'd1 : m_r - 32'd1;

  always_comb begin
    case (q_uop.un)
      UN_PREINC: un_res = m_r + 32'd1;
      UN_PREDEC: un_res = m_r - 32'd1;
      UN_NOT:    un_res = 32'(m_r == 32'd0);
      UN_INV:    un_res = ~m_r;
      UN_ADDR:   un_res = p1_r;
      default:   un_res = m_r;
    endcase
  end

  always_comb begin
    case (q_uop.cls)
      CL_BIN, CL_ASSIGN: alu_out = alu_res;
      CL_UNARY:          alu_out = un_res;
      default:           alu_out = m_r;
    endcase
  end

  sve_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ma),
    .divisor  (mb),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // ---------------- completion ----------------
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign jt = (q_uop.cls == CL_JMP) ||
              ((q_uop.cls == CL_JCOND) && (q_uop.jz == (p2_r == 32'd0)));

  always_comb begin
    case (q_uop.cls)
      CL_PUSH_VAL, CL_PUSH_MEM:    sp_fin = sp_r + 16'd4;
      CL_POP, CL_JMP, CL_BIN, CL_ASSIGN: sp_fin = sp_r - 16'd4;
      CL_JCOND:                    sp_fin = sp_r - 16'd8;
      CL_ADJ:                      sp_fin = nsp[15:0];
      default:                     sp_fin = sp_r;
    endcase
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_START: begin
        if (q_valid) begin
          if (start_fault != FLT_NONE) begin
            state_nxt = ST_FIN;
          end else begin
            case (q_uop.cls)
              CL_HOST:     state_nxt = ST_WRM;
              CL_PUSH_VAL: state_nxt = ST_WRP;
              CL_PUSH_MEM: state_nxt = ST_MRD;
              CL_POP, CL_BIN, CL_UNARY, CL_ASSIGN, CL_JMP, CL_JCOND:
                           state_nxt = ST_POP1;
              default:     state_nxt = ST_FIN;
            endcase
          end
        end
      end
      ST_POP1: state_nxt = two_pop ? ST_POP2 : ST_CHK;
      ST_POP2: state_nxt = ST_CHK;
      ST_CHK: begin
        case (q_uop.cls)
          CL_UNARY: begin
            if (q_uop.un == UN_ADDR) state_nxt = ST_WRP;
            else if (chk_fault)      state_nxt = ST_FIN;
            else                     state_nxt = ST_MRD;
          end
          CL_ASSIGN: state_nxt = chk_fault ? ST_FIN : ST_MRD;
          CL_POP:    state_nxt = (q_uop.arg != 32'd0) ? ST_WRM : ST_FIN;
          CL_BIN:    state_nxt = ST_ALU;
          default:   state_nxt = ST_FIN;
        endcase
      end
      ST_MRD: state_nxt = ST_ALU;
      ST_ALU: begin
        if (div_zero)                   state_nxt = ST_FIN;
        else if (is_div)                state_nxt = ST_DIVW;
        else if (q_uop.cls == CL_ASSIGN) state_nxt = ST_WRM;
        else if (q_uop.cls == CL_UNARY && un_writes) state_nxt = ST_WRM;
        else                            state_nxt = ST_WRP;
      end
      ST_DIVW: begin
        if (div_done) state_nxt = (q_uop.cls == CL_ASSIGN) ? ST_WRM : ST_WRP;
      end
      ST_WRM: begin
        state_nxt = (q_uop.cls == CL_HOST || q_uop.cls == CL_POP) ? ST_FIN : ST_WRP;
      end
      ST_WRP: state_nxt = ST_FIN;
      ST_FIN: if (fin_go) state_nxt = ST_START;
      default: state_nxt = ST_START;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = sp_m4;
    mem_we    = 1'b0;
    mem_waddr = r_r;
    mem_wdata = r_r;
    div_start = 1'b0;
    q_pop     = fin_go;
    case (state_r)
      ST_START: begin
        if (q_valid && start_fault == FLT_NONE) begin
          if (q_uop.cls == CL_PUSH_MEM) begin
            mem_re    = 1'b1;
            mem_raddr = q_uop.data;
          end else if (q_uop.cls == CL_POP || q_uop.cls == CL_UNARY ||
                       q_uop.cls == CL_JMP || two_pop) begin
            mem_re = 1'b1;
          end
        end
      end
      ST_POP1: begin
        mem_re    = two_pop;
        mem_raddr = sp_m8;
      end
      ST_CHK: begin
        if (q_uop.cls == CL_UNARY && q_uop.un != UN_ADDR && !chk_fault) begin
          mem_re    = 1'b1;
          mem_raddr = p1_r;
        end else if (q_uop.cls == CL_ASSIGN && !chk_fault) begin
          mem_re    = 1'b1;
          mem_raddr = p2_r;
        end
      end
      ST_ALU: div_start = is_div && !div_zero;
      ST_WRM: begin
        mem_we = 1'b1;
        case (q_uop.cls)
          CL_HOST: begin
            mem_waddr = q_uop.arg;
            mem_wdata = q_uop.data;
          end
          CL_POP: begin
            mem_waddr = q_uop.arg;
            mem_wdata = p1_r;
          end
          CL_UNARY: begin
            mem_waddr = p1_r;
            mem_wdata = wv;
          end
          default: begin
            mem_waddr = p2_r;
            mem_wdata = r_r;
          end
        endcase
      end
      ST_WRP: begin
        mem_we = 1'b1;
        case (q_uop.cls)
          CL_PUSH_VAL, CL_PUSH_MEM: mem_waddr = sp32;
          CL_UNARY:                 mem_waddr = sp_m4;
          default:                  mem_waddr = sp_m8;
        endcase
      end
      default: ;
    endcase
  end

  // ---------------- memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr[AW+1:2]] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr[AW+1:2]];
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_START;
      sp_r        <= SB_RESET;
      fault_r     <= FLT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (sb_load)
        sp_r <= sb_data;
      else if (fin_go && fault_r == FLT_NONE)
        sp_r <= sp_fin;
      if (fin_go)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
      case (state_r)
        ST_START: if (q_valid) fault_r <= start_fault;
        ST_CHK:   if (chk_fault) fault_r <= FLT_ADDR;
        ST_ALU:   if (div_zero) fault_r <= FLT_DIV0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_START: r_r  <= q_uop.data;
      ST_POP1:  p1_r <= mem_q_r;
      ST_POP2:  p2_r <= mem_q_r;
      ST_CHK:   r_r  <= p1_r;
      ST_MRD:   m_r  <= mem_q_r;
      ST_ALU:   r_r  <= alu_out;
      ST_DIVW:  if (div_done) r_r <= div_fixed;
      default: ;
    endcase
    if (fin_go) begin
      out_fault_r       <= fault_r;
      out_value_r       <= (fault_r == FLT_NONE && q_uop.cls == CL_POP) ? p1_r : 32'd0;
      out_jump_taken_r  <= (fault_r == FLT_NONE) && jt;
      out_jump_target_r <= (fault_r == FLT_NONE && jt) ? p1_r : 32'd0;
      out_stack_level_r <= (fault_r == FLT_NONE) ? sp_fin : sp_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_jump_taken  = out_jump_taken_r;
  assign out_jump_target = out_jump_target_r;
  assign out_stack_level = out_stack_level_r;
  assign out_fault       = out_fault_r;

  // ---------------- assertions ----------------
  a_pop_at_fin: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_FIN) && q_valid)
    else $error("queue popped outside completion");

  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_fault_r != FLT_NONE) |->
      (out_value_r == 32'd0) && !out_jump_taken_r && (out_jump_target_r == 32'd0))
    else $error("faulted result carries data");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_no_write_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (fault_r == FLT_NONE) && (state_r != ST_START))
    else $error("memory written by faulted instruction");

endmodule
